[rtl/segregated_fit_heap_allocator_core_assert.svh]
// ---------------------------------------------------------------------------
// segregated_fit_heap_allocator_core_assert
// assertion helpers for the heap allocator core
// ---------------------------------------------------------------------------
`ifndef SEGREGATED_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define SEGREGATED_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// plain property, sampled on clock, off during reset
`define SFHA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication, same cycle
`define SFHA_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

[rtl/sfha_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sfha_pkg
// types and constants of the segregated-fit heap allocator
// ---------------------------------------------------------------------------
package sfha_pkg;

   localparam int HEAP_WORDS_DEFAULT  = 4096;
   localparam int NUM_CLASSES_DEFAULT = 40;

   localparam int ADDR_W = 14;   // byte offsets on the ports
   localparam int REQ_W  = 14;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOM = 1'b1;

   typedef enum logic [5:0] {
      ST_INIT0, ST_INIT1, ST_IDLE, ST_DONE,
      ST_A_HEAD, ST_A_HEADW, ST_A_HDR, ST_A_NEXT, ST_A_FTRRD, ST_A_FTRW, ST_A_END,
      ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5,
      ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6,
      ST_L0, ST_L1, ST_L2, ST_L2B, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7,
      ST_L8, ST_L9, ST_L10,
      ST_U0, ST_U1, ST_U2, ST_U3
   } state_type;

endpackage
`default_nettype wire

[rtl/segregated_fit_heap_allocator_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// segregated_fit_heap_allocator_core
// boundary-tag heap allocator with address-ordered size-class free lists
// ---------------------------------------------------------------------------
// One request is handled at a time and each step makes at most one access
// to a single port heap memory, so the time per item depends on the heap contents.
// An allocate visits size classes in turn and walks past free blocks that
// are too small, then takes a fitting block (its unlink included), or takes
// the grow path (which may end out of memory) plus an unlink of a free last block.
// A free merges with each free neighbour, unlinking it, then does the
// ordered insert, walking past list blocks. After reset the core writes
// the initial heap tags before it takes an item.
// A finished result sits in an output register, so the next item is taken
// while the previous one still waits to be collected.
`include "segregated_fit_heap_allocator_core_assert.svh"

module segregated_fit_heap_allocator_core
   import sfha_pkg::*;
#(
   parameter int HEAP_WORDS  = HEAP_WORDS_DEFAULT,
   parameter int NUM_CLASSES = NUM_CLASSES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_action,
   input  wire logic [REQ_W-1:0]  req_request_size,
   input  wire logic [ADDR_W-1:0] req_payload_address,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [ADDR_W-1:0]      rsp_granted_address,
   output logic                   rsp_status
);

   localparam int WIW = $clog2(HEAP_WORDS);          // word index
   localparam int AB  = WIW + 2;                     // byte address
   localparam int SW  = AB + 1;                      // heap word
   localparam int CW  = ((SW > REQ_W + 1) ? SW : REQ_W + 1) + 1;
   localparam int CLW = $clog2(NUM_CLASSES);
   localparam logic [CW-1:0]  HEAP_BYTES = CW'(HEAP_WORDS * 4);
   localparam logic [CLW-1:0] LAST_CLASS = CLW'(NUM_CLASSES - 1);
   localparam logic [WIW-1:0] LAST_STEP  = WIW'(HEAP_WORDS - 1);

   function automatic logic [CLW-1:0] class_of(input logic [CW-1:0] size);
      logic [CW-1:0] q;
      q = size >> 4;
      if (q >= CW'(NUM_CLASSES - 1)) return LAST_CLASS;
      return CLW'(q);
   endfunction

   function automatic logic [WIW-1:0] widx(input logic [AB-1:0] b);
      return b[AB-1:2];
   endfunction

   // heap and class-head memories
   logic [SW-1:0] heap_mem [HEAP_WORDS];
   logic [AB-1:0] cls_mem  [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] cls_vld_ff;

   logic           mem_we;
   logic [AB-1:0]  mem_addr;
   logic [SW-1:0]  mem_wdata;
   logic [SW-1:0]  mem_rd_ff;
   logic           cls_we;
   logic [CLW-1:0] cls_addr;
   logic [AB-1:0]  cls_wdata;
   logic [AB-1:0]  cls_rd_ff;
   logic           cls_rvld_ff;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0]  a_ff, a_in, bs_ff, bs_in, ls_ff, ls_in;
   logic [CLW-1:0] c_ff, c_in, u_c_ff, u_c_in;
   logic [AB-1:0]  n_ff, n_in, hdr_ff, hdr_in, ftr_ff, ftr_in, node_ff, node_in;
   logic [AB-1:0]  cur_ff, cur_in, pv_ff, pv_in, u_n_ff, u_n_in;
   logic [WIW-1:0] steps_ff, steps_in;
   logic [SW-1:0]  brk_ff, brk_in;
   logic [AB-1:0]  fin_addr_ff, fin_addr_in;
   logic           fin_status_ff, fin_status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [AB-1:0]  rsp_addr_ff, rsp_addr_in;
   logic           rsp_status_ff, rsp_status_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[widx(mem_addr)] <= mem_wdata;
      end
      mem_rd_ff <= heap_mem[widx(mem_addr)];
      if (cls_we) begin
         cls_mem[cls_addr] <= cls_wdata;
      end
      cls_rd_ff <= cls_mem[cls_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_vld_ff  <= '0;
         cls_rvld_ff <= 1'b0;
      end else begin
         cls_rvld_ff <= cls_vld_ff[cls_addr];
         if (cls_we) begin
            cls_vld_ff[cls_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT0;
         ret_ff       <= ST_IDLE;
         brk_ff       <= SW'(8);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         brk_ff       <= brk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff          <= a_in;
      bs_ff         <= bs_in;
      ls_ff         <= ls_in;
      c_ff          <= c_in;
      u_c_ff        <= u_c_in;
      n_ff          <= n_in;
      hdr_ff        <= hdr_in;
      ftr_ff        <= ftr_in;
      node_ff       <= node_in;
      cur_ff        <= cur_in;
      pv_ff         <= pv_in;
      u_n_ff        <= u_n_in;
      steps_ff      <= steps_in;
      fin_addr_ff   <= fin_addr_in;
      fin_status_ff <= fin_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      logic [CW-1:0] rd_size;
      logic [AB-1:0] rd_link;
      logic [AB-1:0] head;
      logic [CW-1:0] asz;
      logic          next_class;

      rd_size = CW'({mem_rd_ff[SW-1:3], 3'b000});
      rd_link = mem_rd_ff[AB-1:0];
      head    = cls_rvld_ff ? cls_rd_ff : '0;
      asz     = (CW'(req_request_size) + CW'(7)) & ~CW'(7);
      if (asz == '0) asz = CW'(8);
      next_class = 1'b0;

      state_in      = state_ff;
      ret_in        = ret_ff;
      a_in          = a_ff;
      bs_in         = bs_ff;
      ls_in         = ls_ff;
      c_in          = c_ff;
      u_c_in        = u_c_ff;
      n_in          = n_ff;
      hdr_in        = hdr_ff;
      ftr_in        = ftr_ff;
      node_in       = node_ff;
      cur_in        = cur_ff;
      pv_in         = pv_ff;
      u_n_in        = u_n_ff;
      steps_in      = steps_ff;
      brk_in        = brk_ff;
      fin_addr_in   = fin_addr_ff;
      fin_status_in = fin_status_ff;
      mem_we        = 1'b0;
      mem_addr      = '0;
      mem_wdata     = '0;
      cls_we        = 1'b0;
      cls_addr      = c_ff;
      cls_wdata     = '0;
      req_stall     = (state_ff != ST_IDLE);

      // result register: drains on take, loads from the done state
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_INIT0: begin
            mem_we    = 1'b1;
            mem_addr  = AB'(0);
            mem_wdata = SW'(1);
            state_in  = ST_INIT1;
         end
         ST_INIT1: begin
            mem_we    = 1'b1;
            mem_addr  = AB'(4);
            mem_wdata = SW'(1);
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            mem_addr = AB'(req_payload_address) - AB'(4);
            if (req_valid) begin
               if (req_action == ACT_FREE) begin
                  n_in     = AB'(req_payload_address);
                  hdr_in   = AB'(req_payload_address) - AB'(4);
                  state_in = ST_F1;
               end else begin
                  a_in     = asz;
                  c_in     = class_of(asz);
                  state_in = ST_A_HEAD;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = fin_addr_ff;
               rsp_status_in = fin_status_ff;
               state_in      = ST_IDLE;
            end
         end

         // allocate: first fit over the class lists
         ST_A_HEAD: begin
            cls_addr = c_ff;
            state_in = ST_A_HEADW;
         end
         ST_A_HEADW: begin
            if (head == '0) begin
               next_class = 1'b1;
            end else begin
               n_in     = head;
               steps_in = '0;
               mem_addr = head - AB'(4);
               state_in = ST_A_HDR;
            end
         end
         ST_A_HDR: begin
            if (rd_size >= a_ff + CW'(8)) begin
               mem_we    = 1'b1;
               mem_addr  = n_ff - AB'(4);
               mem_wdata = mem_rd_ff | SW'(1);
               bs_in     = rd_size;
               state_in  = ST_A_FTRRD;
            end else begin
               mem_addr = n_ff + AB'(4);
               state_in = ST_A_NEXT;
            end
         end
         ST_A_NEXT: begin
            if (rd_link == '0 || steps_ff == LAST_STEP) begin
               next_class = 1'b1;
            end else begin
               n_in     = rd_link;
               steps_in = steps_ff + WIW'(1);
               mem_addr = rd_link - AB'(4);
               state_in = ST_A_HDR;
            end
         end
         ST_A_FTRRD: begin
            mem_addr = n_ff + AB'(bs_ff) - AB'(8);
            state_in = ST_A_FTRW;
         end
         ST_A_FTRW: begin
            mem_we    = 1'b1;
            mem_addr  = n_ff + AB'(bs_ff) - AB'(8);
            mem_wdata = mem_rd_ff | SW'(1);
            u_c_in    = c_ff;
            u_n_in    = n_ff;
            ret_in    = ST_A_END;
            state_in  = ST_U0;
         end
         ST_A_END: begin
            fin_addr_in   = n_ff;
            fin_status_in = STATUS_OK;
            state_in      = ST_DONE;
         end

         // allocate: grow the break
         ST_G0: begin
            bs_in    = a_ff + CW'(8);
            mem_addr = AB'(brk_ff) - AB'(8);
            state_in = ST_G1;
         end
         ST_G1: begin
            if (mem_rd_ff[0]) begin
               ls_in   = '0;
               node_in = AB'(brk_ff);
            end else begin
               ls_in   = rd_size;
               node_in = AB'(brk_ff) - AB'(rd_size);
            end
            state_in = ST_G2;
         end
         ST_G2: begin
            if (bs_ff > ls_ff && bs_ff - ls_ff > HEAP_BYTES - CW'(brk_ff)) begin
               fin_addr_in   = '0;
               fin_status_in = STATUS_OOM;
               state_in      = ST_DONE;
            end else if (ls_ff != '0) begin
               u_c_in   = class_of(ls_ff);
               u_n_in   = node_ff;
               ret_in   = ST_G3;
               state_in = ST_U0;
            end else begin
               state_in = ST_G3;
            end
         end
         ST_G3: begin
            if (bs_ff > ls_ff) begin
               brk_in = SW'(CW'(brk_ff) + bs_ff - ls_ff);
            end
            mem_we    = 1'b1;
            mem_addr  = node_ff - AB'(4);
            mem_wdata = SW'(bs_ff) | SW'(1);
            state_in  = ST_G4;
         end
         ST_G4: begin
            mem_we    = 1'b1;
            mem_addr  = node_ff + AB'(bs_ff) - AB'(8);
            mem_wdata = SW'(bs_ff) | SW'(1);
            state_in  = ST_G5;
         end
         ST_G5: begin
            mem_we        = 1'b1;
            mem_addr      = node_ff + AB'(bs_ff) - AB'(4);
            mem_wdata     = SW'(1);
            fin_addr_in   = node_ff;
            fin_status_in = STATUS_OK;
            state_in      = ST_DONE;
         end

         // free: merge with neighbours
         ST_F1: begin
            bs_in    = rd_size;
            ftr_in   = n_ff + AB'(rd_size) - AB'(8);
            mem_addr = hdr_ff - AB'(4);
            state_in = ST_F2;
         end
         ST_F2: begin
            if (!mem_rd_ff[0]) begin
               bs_in    = bs_ff + rd_size;
               hdr_in   = hdr_ff - AB'(rd_size);
               u_c_in   = class_of(rd_size);
               u_n_in   = hdr_ff - AB'(rd_size) + AB'(4);
               ret_in   = ST_F3;
               state_in = ST_U0;
            end else begin
               state_in = ST_F3;
            end
         end
         ST_F3: begin
            mem_addr = ftr_ff + AB'(4);
            state_in = ST_F4;
         end
         ST_F4: begin
            if (!mem_rd_ff[0]) begin
               bs_in    = bs_ff + rd_size;
               u_c_in   = class_of(rd_size);
               u_n_in   = ftr_ff + AB'(8);
               ftr_in   = ftr_ff + AB'(rd_size);
               ret_in   = ST_F5;
               state_in = ST_U0;
            end else begin
               state_in = ST_F5;
            end
         end
         ST_F5: begin
            mem_we    = 1'b1;
            mem_addr  = hdr_ff;
            mem_wdata = SW'(bs_ff);
            state_in  = ST_F6;
         end
         ST_F6: begin
            mem_we    = 1'b1;
            mem_addr  = ftr_ff;
            mem_wdata = SW'(bs_ff);
            c_in      = class_of(bs_ff);
            n_in      = hdr_ff + AB'(4);
            state_in  = ST_L0;
         end

         // ordered insert of n into list c
         ST_L0: begin
            cls_addr = c_ff;
            state_in = ST_L1;
         end
         ST_L1: begin
            if (head == '0) begin
               cls_we    = 1'b1;
               cls_addr  = c_ff;
               cls_wdata = n_ff;
               state_in  = ST_L2;
            end else begin
               cur_in   = head;
               steps_in = '0;
               state_in = ST_L3;
            end
         end
         ST_L2: begin
            mem_we   = 1'b1;
            mem_addr = n_ff;
            state_in = ST_L2B;
         end
         ST_L2B: begin
            mem_we        = 1'b1;
            mem_addr      = n_ff + AB'(4);
            fin_addr_in   = '0;
            fin_status_in = STATUS_OK;
            state_in      = ST_DONE;
         end
         ST_L3: begin
            if (n_ff < cur_ff) begin
               mem_addr = cur_ff;
               state_in = ST_L4;
            end else begin
               mem_addr = cur_ff + AB'(4);
               state_in = ST_L8;
            end
         end
         ST_L4: begin
            pv_in     = rd_link;
            mem_we    = 1'b1;
            mem_addr  = n_ff;
            mem_wdata = SW'(rd_link);
            state_in  = ST_L5;
         end
         ST_L5: begin
            mem_we    = 1'b1;
            mem_addr  = n_ff + AB'(4);
            mem_wdata = SW'(cur_ff);
            state_in  = ST_L6;
         end
         ST_L6: begin
            mem_we    = 1'b1;
            mem_addr  = cur_ff;
            mem_wdata = SW'(n_ff);
            state_in  = ST_L7;
         end
         ST_L7: begin
            if (pv_ff == '0) begin
               cls_we    = 1'b1;
               cls_addr  = c_ff;
               cls_wdata = n_ff;
            end else begin
               mem_we    = 1'b1;
               mem_addr  = pv_ff + AB'(4);
               mem_wdata = SW'(n_ff);
            end
            fin_addr_in   = '0;
            fin_status_in = STATUS_OK;
            state_in      = ST_DONE;
         end
         ST_L8: begin
            fin_addr_in   = '0;
            fin_status_in = STATUS_OK;
            if (rd_link == '0) begin
               mem_we    = 1'b1;
               mem_addr  = n_ff;
               mem_wdata = SW'(cur_ff);
               state_in  = ST_L9;
            end else begin
               cur_in = rd_link;
               // a list that never ends leaves the block off every list
               if (steps_ff == LAST_STEP) begin
                  state_in = ST_DONE;
               end else begin
                  steps_in = steps_ff + WIW'(1);
                  state_in = ST_L3;
               end
            end
         end
         ST_L9: begin
            mem_we   = 1'b1;
            mem_addr = n_ff + AB'(4);
            state_in = ST_L10;
         end
         ST_L10: begin
            mem_we    = 1'b1;
            mem_addr  = cur_ff + AB'(4);
            mem_wdata = SW'(n_ff);
            state_in  = ST_DONE;
         end

         // unlink u_n from list u_c, then back to ret
         ST_U0: begin
            mem_addr = u_n_ff;
            state_in = ST_U1;
         end
         ST_U1: begin
            pv_in    = rd_link;
            mem_addr = u_n_ff + AB'(4);
            state_in = ST_U2;
         end
         ST_U2: begin
            cur_in = rd_link;
            if (pv_ff == '0) begin
               cls_we    = 1'b1;
               cls_addr  = u_c_ff;
               cls_wdata = rd_link;
            end else begin
               mem_we    = 1'b1;
               mem_addr  = pv_ff + AB'(4);
               mem_wdata = SW'(rd_link);
            end
            state_in = ST_U3;
         end
         ST_U3: begin
            if (cur_ff != '0) begin
               mem_we    = 1'b1;
               mem_addr  = cur_ff;
               mem_wdata = SW'(pv_ff);
            end
            state_in = ret_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (next_class) begin
         if (c_ff == LAST_CLASS) begin
            state_in = ST_G0;
         end else begin
            c_in     = c_ff + CLW'(1);
            state_in = ST_A_HEAD;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = ADDR_W'(rsp_addr_ff);
   assign rsp_status          = rsp_status_ff;

   `SFHA_ASSERT_IMP(a_oom_no_addr,
      rsp_valid_ff && rsp_status_ff == STATUS_OOM, rsp_addr_ff == '0,
      "out of memory item carries an address")
   `SFHA_ASSERT(a_brk_range,
      brk_ff[2:0] == 3'b000 && CW'(brk_ff) <= HEAP_BYTES && brk_ff >= SW'(8),
      "heap break out of range or misaligned")
   `SFHA_ASSERT_IMP(a_no_write_idle,
      mem_we || cls_we, state_ff != ST_IDLE && state_ff != ST_DONE,
      "memory written outside a request")

endmodule
`default_nettype wire

[verif/tb_segregated_fit_heap_allocator_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_segregated_fit_heap_allocator_core
// self-checking bench for the segregated-fit heap allocator core
// ---------------------------------------------------------------------------
// Allocates and frees blocks against a behavioural copy of the heap, its tags
// and its class lists. Each granted address and status is checked in order.
// Frees only ever name live grants, so a free never reads an unwritten heap word.
// Both channels idle in random bursts, and the response side holds off once
// for a long stretch so that the core backs up and stalls its input.
// ---------------------------------------------------------------------------
module tb_segregated_fit_heap_allocator_core
   import sfha_pkg::*;
();

   localparam int unsigned WORDS   = HEAP_WORDS_DEFAULT;
   localparam int unsigned CLASSES = NUM_CLASSES_DEFAULT;
   localparam int unsigned BYTES   = WORDS * 4;
   localparam int unsigned NUM_RANDOM = 1080;

   typedef struct {
      logic [ADDR_W-1:0] granted;
      logic              status;
   } grant_type;

   class heap_scoreboard_type;
      int unsigned heap_mem[WORDS];
      int unsigned heads[CLASSES];
      int unsigned brk;
      grant_type   awaited[$];
      int          fails;

      function new();
         foreach (heap_mem[i]) heap_mem[i] = 0;
         foreach (heads[i]) heads[i] = 0;
         heap_mem[0] = 1;
         heap_mem[1] = 1;
         brk = 8;
         fails = 0;
      endfunction

      function int unsigned peek(int unsigned b);
         return heap_mem[(b >> 2) % WORDS];
      endfunction

      function void poke(int unsigned b, int unsigned v);
         heap_mem[(b >> 2) % WORDS] = v;
      endfunction

      function int unsigned size_class(int unsigned sz);
         int unsigned q;
         q = sz / 16;
         return (q >= CLASSES - 1) ? CLASSES - 1 : q;
      endfunction

      function void take_off(int unsigned c, int unsigned n);
         int unsigned pv, nx;
         pv = peek(n);
         nx = peek(n + 4);
         if (pv == 0) heads[c] = nx;
         else poke(pv + 4, nx);
         if (nx != 0) poke(nx, pv);
      endfunction

      function void put_on(int unsigned c, int unsigned n);
         int unsigned cur, pv;
         cur = heads[c];
         if (cur == 0) begin
            heads[c] = n;
            poke(n, 0);
            poke(n + 4, 0);
            return;
         end
         for (int unsigned k = 0; k < WORDS; k++) begin
            if (n < cur) begin
               pv = peek(cur);
               poke(n, pv);
               poke(n + 4, cur);
               poke(cur, n);
               if (pv == 0) heads[c] = n;
               else poke(pv + 4, n);
               return;
            end
            if (peek(cur + 4) == 0) begin
               poke(n, cur);
               poke(n + 4, 0);
               poke(cur + 4, n);
               return;
            end
            cur = peek(cur + 4);
         end
      endfunction

      function grant_type grab(int unsigned req);
         int unsigned a, n, bs, lf, lw, ls, node;
         grant_type g;
         a = (req + 7) & ~32'h7;
         if (a == 0) a = 8;
         g.status = STATUS_OK;
         for (int unsigned c = size_class(a); c < CLASSES; c++) begin
            n = heads[c];
            for (int unsigned k = 0; n != 0 && k < WORDS; k++) begin
               bs = peek(n - 4) & ~32'h7;
               if (bs >= a + 8) begin
                  poke(n - 4, peek(n - 4) | 1);
                  poke(n + bs - 8, peek(n + bs - 8) | 1);
                  take_off(c, n);
                  g.granted = n[ADDR_W-1:0];
                  return g;
               end
               n = peek(n + 4);
            end
         end
         // grow the break, absorbing a free last block
         bs = a + 8;
         lf = brk - 8;
         lw = peek(lf);
         if (lw & 1) begin
            ls = 0;
            node = lf + 8;
         end else begin
            ls = lw & ~32'h7;
            node = lf - ls + 8;
         end
         if (bs > ls && bs - ls > BYTES - brk) begin
            g.status = STATUS_OOM;
            g.granted = '0;
            return g;
         end
         if (ls != 0) take_off(size_class(ls), node);
         if (bs > ls) brk += bs - ls;
         poke(node - 4, bs | 1);
         poke(node + bs - 8, bs | 1);
         poke(node + bs - 4, 1);
         g.granted = node[ADDR_W-1:0];
         return g;
      endfunction

      function void release_block(int unsigned p);
         int unsigned hdr, bs, ftr, w, ps, ns;
         hdr = p - 4;
         bs = peek(hdr) & ~32'h7;
         ftr = p + bs - 8;
         w = peek(hdr - 4);
         if (!(w & 1)) begin
            ps = w & ~32'h7;
            bs += ps;
            hdr -= ps;
            take_off(size_class(ps), hdr + 4);
         end
         w = peek(ftr + 4);
         if (!(w & 1)) begin
            ns = w & ~32'h7;
            bs += ns;
            take_off(size_class(ns), ftr + 8);
            ftr += ns;
         end
         poke(hdr, bs);
         poke(ftr, bs);
         put_on(size_class(bs), hdr + 4);
      endfunction

      function grant_type note_input(logic act, int unsigned req, int unsigned paddr);
         grant_type g;
         if (act == ACT_ALLOC) g = grab(req);
         else begin
            release_block(paddr);
            g.granted = '0;
            g.status = STATUS_OK;
         end
         awaited.push_back(g);
         return g;
      endfunction

      function void check_result(logic [ADDR_W-1:0] granted, logic status);
         grant_type g;
         if (awaited.size() == 0) begin
            $error("unexpected item: granted_address %0d status %0d", granted, status);
            fails++;
            return;
         end
         g = awaited.pop_front();
         if (granted !== g.granted) begin
            $error("granted_address: expected %0d, actual %0d", g.granted, granted);
            fails++;
         end
         if (status !== g.status) begin
            $error("status: expected %0d, actual %0d", g.status, status);
            fails++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = ACT_ALLOC;
   logic [REQ_W-1:0]  req_request_size = '0;
   logic [ADDR_W-1:0] req_payload_address = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ADDR_W-1:0] rsp_granted_address;
   logic              rsp_status;

   heap_scoreboard_type sb = new();
   int unsigned         live_blocks[$];
   int                  items_sent = 0;
   bit                  quiet = 1'b0;

   segregated_fit_heap_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_request_size(req_request_size),
      .req_payload_address(req_payload_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_granted_address(rsp_granted_address), .rsp_status(rsp_status)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // one item, held until taken; stall is sampled mid-cycle, away from the edge
   task automatic send_item(logic act, int unsigned req, int unsigned paddr);
      bit        stalled;
      grant_type g;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_request_size <= req[REQ_W-1:0];
      req_payload_address <= paddr[ADDR_W-1:0];
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      g = sb.note_input(act, req, paddr);
      if (act == ACT_ALLOC && g.status == STATUS_OK) live_blocks.push_back(g.granted);
      items_sent++;
      if (items_sent > 950) quiet = 1'b1;
   endtask

   task automatic alloc_item(int unsigned req);
      send_item(ACT_ALLOC, req, $urandom_range(0, 16383));
   endtask

   task automatic free_item(int unsigned idx);
      int unsigned p;
      p = live_blocks[idx];
      live_blocks.delete(idx);
      send_item(ACT_FREE, $urandom_range(0, 16383), p);
   endtask

   initial begin
      int unsigned pick, req;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // zero and tiny sizes, class edges
      alloc_item(0);
      alloc_item(1);
      alloc_item(8);
      alloc_item(9);
      alloc_item(16);
      alloc_item(640);
      alloc_item(16376);          // cannot fit
      alloc_item(100);
      alloc_item(24);
      // merge with both neighbours
      free_item(3);
      free_item(4);
      free_item(3);
      alloc_item(24);             // from a list
      alloc_item(2);
      // free last block, then reuse it in place without growing
      alloc_item(500);
      free_item(live_blocks.size() - 1);
      alloc_item(100);
      free_item(live_blocks.size() - 1);
      alloc_item(900);            // absorb and grow
      alloc_item(15000);
      free_item(0);
      alloc_item(3);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (live_blocks.size() != 0 &&
             ($urandom_range(0, 99) < (live_blocks.size() > 40 ? 70 : 40))) begin
            free_item($urandom_range(0, live_blocks.size() - 1));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) req = $urandom_range(0, 64);
            else if (pick < 90) req = $urandom_range(65, 700);
            else if (pick < 98) req = $urandom_range(701, 4000);
            else req = $urandom_range(4001, 16376);
            alloc_item(req);
         end
      end
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.fails == 0)
         $display("** segregated_fit_heap_allocator_core: PASSED **");
      else
         $display("** segregated_fit_heap_allocator_core: FAILED **");
      $finish;
   end

   // response side back-pressure, with one long hold-off
   initial begin
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && items_sent >= 400) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      bit                taken;
      logic [ADDR_W-1:0] granted;
      logic              status;
      forever begin
         @(negedge clock);
         taken = !reset && rsp_valid && !rsp_stall;
         granted = rsp_granted_address;
         status = rsp_status;
         @(posedge clock);
         if (taken) sb.check_result(granted, status);
      end
   end

   initial begin
      #8ms;
      $display("** segregated_fit_heap_allocator_core: FAILED **");
      $finish;
   end

endmodule

[segregated_fit_heap_allocator_core.f]
+incdir+rtl
rtl/sfha_pkg.sv
rtl/segregated_fit_heap_allocator_core.sv
verif/tb_segregated_fit_heap_allocator_core.sv
